// File: design/mwf_pkg.sv
// ---------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants of the membrane wave block.
// ---------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

    localparam int GRID_DEF = 64;
    localparam int DATA_W   = 32;

    // shared multiplier: A is split into a signed high part and an
    // unsigned low part of MUL_SPLIT bits
    localparam int MUL_AW    = 40;
    localparam int MUL_BW    = 26;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_SPLIT = 20;

    typedef struct packed {
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_in;

endpackage

`default_nettype wire

// File: design/membrane_wave_fdtd_step.sv
// ---------------------------------------------------------------------------
// membrane_wave_fdtd_step
// Square membrane simulator: strikes and damped wave-equation time steps.
// ---------------------------------------------------------------------------
// Past, present and next displacement planes live in three banks of one
// RAM (one write, two registered reads); a time step reads present and past,
// writes the next bank and then rotates bank roles, so no copy is needed.
// After reset the block sweeps the whole RAM to zero with busy high. A step
// visits every interior cell in turn with five neighbor reads and three
// passes through the shared multiplier, after a setup and before the
// microphone mix. A strike works through a 7x7 patch cell by cell and skips
// cells off the grid interior. The sample strobe lasts one cycle and cannot
// be held off; strikes give no sample.
// ---------------------------------------------------------------------------
`default_nettype none

module membrane_wave_fdtd_step #(
    parameter int GRID = mwf_pkg::GRID_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic                          i_action,
    input  wire logic [5:0]                    i_strike_x,
    input  wire logic [5:0]                    i_strike_y,
    input  wire logic signed [31:0]            i_strike_force,
    input  wire logic                          i_stiffness_on,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [16:0]                   i_cfg_data,
    output logic                               o_sample_valid,
    output logic signed [mwf_pkg::DATA_W-1:0]  o_sample
);
    import mwf_pkg::*;

    localparam int CW    = $clog2(GRID);
    localparam int MAW   = 2 * CW + 2;
    localparam int DEPTH = 1 << MAW;
    localparam int LAST  = GRID - 2;
    localparam int SW    = 2 * CW + 8;
    localparam logic signed [SW-1:0] R2 = SW'((GRID - 2) * (GRID - 2));

    localparam logic [CW-1:0] TAP1_X = CW'(GRID * 45 / 100);
    localparam logic [CW-1:0] TAP1_Y = CW'(GRID * 55 / 100);
    localparam logic [CW-1:0] TAP2_X = CW'(GRID * 25 / 100);
    localparam logic [CW-1:0] TAP2_Y = CW'(GRID * 65 / 100);
    localparam logic [CW-1:0] TAP3_X = CW'(GRID * 80 / 100);
    localparam logic [CW-1:0] TAP3_Y = CW'(GRID * 40 / 100);

    localparam logic signed [MUL_BW-1:0] MIX_C1  = 26'sd5033165;
    localparam logic signed [MUL_BW-1:0] MIX_C2  = 26'sd8388608;
    localparam logic signed [MUL_BW-1:0] MIX_C3  = 26'sd3355443;
    localparam logic signed [MUL_BW-1:0] STIFF_C = 26'sd33554;
    localparam logic [26:0] RECIP_100 = 27'd85899346;

    localparam logic [1:0] CFG_WAVE_SPEED = 2'd0;
    localparam logic [1:0] CFG_DAMPING    = 2'd1;
    localparam logic [1:0] CFG_CIRCULAR   = 2'd2;

    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_STRIKE, S_SETUP, S_CELL, S_MIX
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // round(2^24 / (1 + d))
    function automatic logic [24:0] strike_weight(input logic [4:0] d);
        logic [24:0] w;
        case (d)
            5'd0:    w = 25'd16777216;
            5'd1:    w = 25'd8388608;
            5'd2:    w = 25'd5592405;
            5'd4:    w = 25'd3355443;
            5'd5:    w = 25'd2796203;
            5'd8:    w = 25'd1864135;
            5'd9:    w = 25'd1677722;
            5'd10:   w = 25'd1525201;
            5'd13:   w = 25'd1198373;
            5'd18:   w = 25'd883011;
            default: w = 25'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] off_sq(input logic [2:0] o);
        logic [3:0] s;
        case (o)
            3'd0, 3'd6: s = 4'd9;
            3'd1, 3'd5: s = 4'd4;
            3'd2, 3'd4: s = 4'd1;
            default:    s = 4'd0;
        endcase
        return s;
    endfunction

    // registers
    t_state              r_state;
    logic [MAW-1:0]      r_clr;
    logic [3:0]          r_ph;
    logic [1:0]          r_bp, r_bc, r_bn;
    logic [14:0]         r_wave_speed;
    logic [16:0]         r_damping;
    logic                r_circ;
    logic [5:0]          r_cx, r_cy;
    logic signed [31:0]  r_force;
    logic                r_stiff;
    logic [2:0]          r_dx, r_dy;
    logic [CW-1:0]       r_sx, r_sy;
    logic signed [31:0]  r_vc, r_vp;
    logic signed [41:0]  r_local;
    logic [CW-1:0]       r_x, r_y;
    logic                r_mask;
    logic signed [35:0]  r_lc, r_lp;
    logic signed [31:0]  r_pc, r_pp;
    logic [20:0]         r_rho2;
    logic [52:0]         r_gprod;
    logic [24:0]         r_gain;
    logic signed [39:0]  r_t1, r_st, r_raw;
    logic signed [67:0]  r_mix;

    // ram and multiplier hookup
    logic                ram_we;
    logic [MAW-1:0]      ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [31:0]         ram_wdata, ram_rdata_a, ram_rdata_b;
    t_mul_in             mul_req;
    logic signed [MUL_PW-1:0] mul_prod;

    mwf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    mwf_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // strike patch geometry
    logic signed [9:0] sx, sy;
    logic              patch_ok;
    logic [4:0]        patch_d;

    assign sx = $signed(10'(r_cx) + 10'(r_dx) - 10'd3);
    assign sy = $signed(10'(r_cy) + 10'(r_dy) - 10'd3);
    assign patch_ok = (sx >= 10'sd1) && (sx <= $signed(10'(LAST)))
                   && (sy >= 10'sd1) && (sy <= $signed(10'(LAST)));
    assign patch_d  = 5'(off_sq(r_dx)) + 5'(off_sq(r_dy));

    // circular mask for the current cell
    logic signed [CW+2:0] ex, ey;
    logic signed [SW-1:0] rad2;

    assign ex   = $signed({2'b00, r_x, 1'b0}) - $signed((CW+3)'(GRID));
    assign ey   = $signed({2'b00, r_y, 1'b0}) - $signed((CW+3)'(GRID));
    assign rad2 = SW'(ex * ex) + SW'(ey * ey);

    // rounded views of the product
    logic signed [MUL_PW-1:0] prod_r20, prod_r24;
    logic signed [41:0]       prod_s24;
    logic signed [67:0]       mix_r;

    assign prod_r20 = mul_prod + (MUL_PW'(1) <<< 19);
    assign prod_r24 = mul_prod + (MUL_PW'(1) <<< 23);
    assign prod_s24 = $signed(prod_r24[MUL_PW-1:24]);
    assign mix_r    = r_mix + (68'sd1 <<< 23);

    // gain and rho^2 inputs
    logic [16:0] dmp_eff;
    logic [16:0] loss;
    logic [25:0] loss_n;

    assign dmp_eff = (r_damping > 17'd65536) ? 17'd65536 : r_damping;
    assign loss    = 17'd65536 - dmp_eff;
    assign loss_n  = {loss, 9'd0} + 26'd50;

    logic [CW-1:0] nb_x, nb_y;
    logic signed [36:0] lap_diff;

    assign lap_diff = 37'(r_lc) - 37'(r_lp);

    always_comb begin
        case (r_ph[2:0])
            3'd1:    begin nb_x = r_x - 1'b1; nb_y = r_y;        end
            3'd2:    begin nb_x = r_x + 1'b1; nb_y = r_y;        end
            3'd3:    begin nb_x = r_x;        nb_y = r_y - 1'b1; end
            3'd4:    begin nb_x = r_x;        nb_y = r_y + 1'b1; end
            default: begin nb_x = r_x;        nb_y = r_y;        end
        endcase
    end

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_raddr_a = {r_bc, nb_x, nb_y};
        ram_raddr_b = {r_bp, nb_x, nb_y};
        mul_req.a   = '0;
        mul_req.b   = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_STRIKE: begin
                ram_raddr_a = {r_bc, sx[CW-1:0], sy[CW-1:0]};
                ram_raddr_b = {r_bp, sx[CW-1:0], sy[CW-1:0]};
                mul_req.a   = MUL_AW'(r_force);
                mul_req.b   = $signed({1'b0, strike_weight(patch_d)});
                if (r_ph == 4'd4) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_bc, r_sx, r_sy};
                    ram_wdata = sat32(64'($signed(r_vc)) + 64'(r_local));
                end else if (r_ph == 4'd5) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_bp, r_sx, r_sy};
                    ram_wdata = sat32(64'($signed(r_vp)) + 64'(r_local));
                end
            end
            S_CELL: begin
                case (r_ph)
                    4'd6: begin
                        mul_req.a = MUL_AW'(r_lc);
                        mul_req.b = $signed({5'd0, r_rho2});
                    end
                    4'd7: begin
                        mul_req.a = MUL_AW'(lap_diff);
                        mul_req.b = STIFF_C;
                    end
                    4'd12: begin
                        mul_req.a = r_raw;
                        mul_req.b = $signed({1'b0, r_gain});
                    end
                    4'd15: begin
                        ram_we    = 1'b1;
                        ram_waddr = {r_bn, r_x, r_y};
                        ram_wdata = r_mask ? 32'd0 : sat32(64'(prod_s24));
                    end
                    default: begin
                    end
                endcase
            end
            S_MIX: begin
                case (r_ph)
                    4'd0: ram_raddr_a = {r_bn, TAP1_X, TAP1_Y};
                    4'd1: ram_raddr_a = {r_bn, TAP2_X, TAP2_Y};
                    4'd2: ram_raddr_a = {r_bn, TAP3_X, TAP3_Y};
                    default: begin
                    end
                endcase
                mul_req.a = MUL_AW'($signed(ram_rdata_a));
                case (r_ph)
                    4'd1:    mul_req.b = MIX_C1;
                    4'd2:    mul_req.b = MIX_C2;
                    4'd3:    mul_req.b = MIX_C3;
                    default: mul_req.b = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_ph           <= '0;
            r_bp           <= 2'd0;
            r_bc           <= 2'd1;
            r_bn           <= 2'd2;
            r_wave_speed   <= 15'd16384;
            r_damping      <= 17'd65536;
            r_circ         <= 1'b0;
            o_sample_valid <= 1'b0;
        end else begin
            o_sample_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WAVE_SPEED: r_wave_speed <= i_cfg_data[14:0];
                    CFG_DAMPING:    r_damping    <= i_cfg_data;
                    CFG_CIRCULAR:   r_circ       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cx    <= i_strike_x;
                        r_cy    <= i_strike_y;
                        r_force <= i_strike_force;
                        r_stiff <= i_stiffness_on;
                        r_dx    <= '0;
                        r_dy    <= '0;
                        r_ph    <= '0;
                        r_state <= (i_action == ACT_STEP) ? S_SETUP : S_STRIKE;
                    end
                end
                S_STRIKE: begin
                    // each patch cell is read, updated and written before the
                    // next one is touched
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 4'd0) begin
                        r_sx <= sx[CW-1:0];
                        r_sy <= sy[CW-1:0];
                    end
                    if (r_ph == 4'd1) begin
                        r_vc <= $signed(ram_rdata_a);
                        r_vp <= $signed(ram_rdata_b);
                    end
                    if (r_ph == 4'd3) begin
                        r_local <= prod_s24;
                    end
                    if ((r_ph == 4'd0 && !patch_ok) || r_ph == 4'd5) begin
                        r_ph <= '0;
                        if (r_dy == 3'd6) begin
                            r_dy <= '0;
                            r_dx <= r_dx + 1'b1;
                            if (r_dx == 3'd6) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_dy <= r_dy + 1'b1;
                        end
                    end
                end
                S_SETUP: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 4'd0) begin
                        r_rho2  <= 21'((31'(r_wave_speed) * 31'(r_wave_speed)
                                        + 31'd512) >> 10);
                        r_gprod <= 53'(loss_n) * 53'(RECIP_100);
                    end else begin
                        r_gain  <= 25'd16777216 - 25'(r_gprod[52:33]);
                        r_x     <= CW'(1);
                        r_y     <= CW'(1);
                        r_ph    <= '0;
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_ph <= r_ph + 1'b1;
                    case (r_ph)
                        4'd0: r_mask <= r_circ && (rad2 >= R2);
                        4'd1: begin
                            r_pc <= $signed(ram_rdata_a);
                            r_pp <= $signed(ram_rdata_b);
                            r_lc <= -(36'($signed(ram_rdata_a)) <<< 2);
                            r_lp <= -(36'($signed(ram_rdata_b)) <<< 2);
                        end
                        4'd2, 4'd3, 4'd4, 4'd5: begin
                            r_lc <= r_lc + 36'($signed(ram_rdata_a));
                            r_lp <= r_lp + 36'($signed(ram_rdata_b));
                        end
                        4'd9:  r_t1 <= $signed(prod_r20[59:20]);
                        4'd10: r_st <= r_stiff ? 40'(prod_s24) : 40'sd0;
                        4'd11: r_raw <= r_t1 + (40'(r_pc) <<< 1) - 40'(r_pp) + r_st;
                        4'd15: begin
                            if (r_y == CW'(LAST)) begin
                                r_y <= CW'(1);
                                if (r_x == CW'(LAST)) begin
                                    r_state <= S_MIX;
                                end else begin
                                    r_x <= r_x + 1'b1;
                                end
                            end else begin
                                r_y <= r_y + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_MIX: begin
                    r_ph <= r_ph + 1'b1;
                    case (r_ph)
                        4'd4: r_mix <= 68'(mul_prod);
                        4'd5, 4'd6: r_mix <= r_mix + 68'(mul_prod);
                        4'd7: begin
                            o_sample       <= sat32(64'($signed(mix_r[67:24])));
                            o_sample_valid <= 1'b1;
                            // past <- present <- next; old past bank is reused
                            r_bp    <= r_bc;
                            r_bc    <= r_bn;
                            r_bn    <= r_bp;
                            r_ph    <= '0;
                            r_state <= S_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_banks_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp != r_bc) && (r_bc != r_bn) && (r_bp != r_bn))
        else $error("bank roles collide");

    a_step_writes_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && ram_we) |-> (ram_waddr[MAW-1 -: 2] == r_bn))
        else $error("step wrote outside the next bank");

    a_sample_after_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample_valid |-> $past(r_state == S_MIX))
        else $error("sample strobe without a finished step");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample_valid |=> !o_sample_valid)
        else $error("sample strobe longer than one cycle");

endmodule

`default_nettype wire

// File: design/mwf_ram.sv
// ---------------------------------------------------------------------------
// mwf_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: design/mwf_mul.sv
// ---------------------------------------------------------------------------
// mwf_mul
// Pipelined signed multiplier built from two partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_mul (
    input  wire logic               i_clk,
    input  wire mwf_pkg::t_mul_in   i_req,
    output logic signed [mwf_pkg::MUL_PW-1:0] o_prod
);
    import mwf_pkg::*;

    localparam int HW = MUL_AW - MUL_SPLIT;

    t_mul_in                              r_req;
    logic signed [HW+MUL_BW-1:0]          r_hi;
    logic signed [MUL_SPLIT+MUL_BW:0]     r_lo;

    logic signed [HW-1:0]        a_hi;
    logic signed [MUL_SPLIT:0]   a_lo;

    assign a_hi = r_req.a[MUL_AW-1:MUL_SPLIT];
    assign a_lo = $signed({1'b0, r_req.a[MUL_SPLIT-1:0]});

    always_ff @(posedge i_clk) begin
        r_req  <= i_req;
        r_hi   <= a_hi * r_req.b;
        r_lo   <= a_lo * r_req.b;
        o_prod <= (MUL_PW'(r_hi) <<< MUL_SPLIT) + MUL_PW'(r_lo);
    end

endmodule

`default_nettype wire
